/* design/boris_particle_push_assert.svh */
// Assertion macros used by the particle push top level.
`ifndef BORIS_PARTICLE_PUSH_ASSERT_SVH
`define BORIS_PARTICLE_PUSH_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BPP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bpp_pkg.sv */
// Package with the types, constants and saturating fixed-point helpers of the particle push.
package bpp_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TS_WIDTH   = 21;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [DATA_WIDTH-1:0]   word_type;
   typedef logic signed [2*DATA_WIDTH:0]   wide_type;
   typedef logic [2:0][DATA_WIDTH-1:0]     vec_type;
   typedef logic [5:0][DATA_WIDTH-1:0]     prod_type;
   typedef logic [CSR_IDX_W-1:0]           csr_idx_type;
   typedef logic [TS_WIDTH-1:0]            ts_type;

   // Register indexes of the configuration port.
   localparam csr_idx_type CSR_TIME_STEP = csr_idx_type'(0);
   localparam csr_idx_type CSR_QM        = csr_idx_type'(1);

   localparam ts_type   TS_RESET = ts_type'(6554);
   localparam word_type QM_RESET = word_type'(-65536);

   localparam word_type WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam wide_type WIDE_MAX = wide_type'(WORD_MAX);
   localparam wide_type WIDE_MIN = wide_type'(WORD_MIN);
   localparam word_type ONE_Q    = word_type'(1) <<< FRAC_BITS;

   // Rotation scale divider: quotient bits and working width.
   localparam int QBITS = FRAC_BITS + 2;
   localparam int DIV_W = DATA_WIDTH + QBITS + 1;
   typedef logic [DIV_W-1:0] div_type;
   typedef logic [QBITS-1:0] quot_type;
   localparam quot_type QUOT_MAX = quot_type'(1) << (FRAC_BITS + 1);

   // Stage where the scale is ready, and the output stage.
   localparam int STG_S    = 3 + QBITS;
   localparam int STG_LAST = STG_S + 4;
   localparam int DLY_N    = STG_S - 5;

   // Cyclic neighbors of a component for the cross product.
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type vel_x;
      word_type vel_y;
      word_type vel_z;
      word_type efield_x;
      word_type efield_y;
      word_type efield_z;
      word_type bfield_x;
      word_type bfield_y;
      word_type bfield_z;
   } req_data_type;

   typedef struct packed {
      word_type new_pos_x;
      word_type new_pos_y;
      word_type new_pos_z;
      word_type new_vel_x;
      word_type new_vel_y;
      word_type new_vel_z;
   } rsp_data_type;

   // Values carried while the rotation scale is computed.
   typedef struct packed {
      vec_type kick;
      vec_type um;
      vec_type xh;
      vec_type w;
   } dly_type;

   // Clamp a wide signed value to the word range.
   function automatic word_type sat_wide(input wide_type v);
      word_type r;
      if (v > WIDE_MAX) r = WORD_MAX;
      else if (v < WIDE_MIN) r = WORD_MIN;
      else r = v[DATA_WIDTH-1:0];
      return r;
   endfunction

   // Saturating add.
   function automatic word_type add_sat(input word_type a, input word_type b);
      logic [DATA_WIDTH:0] s;
      word_type r;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) r = s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      else r = s[DATA_WIDTH-1:0];
      return r;
   endfunction

   // Saturating subtract.
   function automatic word_type sub_sat(input word_type a, input word_type b);
      logic [DATA_WIDTH:0] s;
      word_type r;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) r = s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      else r = s[DATA_WIDTH-1:0];
      return r;
   endfunction

   // Product shifted right by sh bits, rounded half up, saturated.
   function automatic word_type mul_round(input word_type a, input word_type b, input int sh);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      p = p + (wide_type'(1) <<< (sh - 1));
      p = p >>> sh;
      return sat_wide(p);
   endfunction

endpackage

/* design/bpp_req_if.sv */
// Request channel interface carrying one particle word.
interface bpp_req_if;
   import bpp_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/bpp_rsp_if.sv */
// Response channel interface carrying one pushed particle word.
interface bpp_rsp_if;
   import bpp_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/bpp_div.sv */
// Pipelined restoring divider for the rotation scale, one quotient bit per stage.
module bpp_div (
   input  logic               clock,
   input  logic               en,
   input  bpp_pkg::word_type  den,
   output bpp_pkg::quot_type  quot
);
   import bpp_pkg::*;

   div_type  rem_ff [QBITS];
   div_type  den_ff [QBITS];
   quot_type q_ff   [QBITS];
   div_type  num;

   // Dividend is 2.0 in double fraction format plus half the divisor, for rounding.
   assign num = (div_type'(1) << (2*FRAC_BITS + 1)) + div_type'(den[DATA_WIDTH-2:1]);

   for (genvar i = 0; i < QBITS; i++) begin : g_stage
      div_type  rem_src;
      div_type  den_src;
      quot_type q_src;
      div_type  trial;
      logic     fits;
      div_type  rem_in;
      quot_type q_in;

      if (i == 0) begin : g_first
         assign rem_src = num;
         assign den_src = div_type'(den[DATA_WIDTH-2:0]);
         assign q_src   = '0;
      end else begin : g_rest
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign q_src   = q_ff[i-1];
      end

      // Try to take the shifted divisor out of the remainder.
      assign trial  = den_src << (QBITS - 1 - i);
      assign fits   = rem_src >= trial;
      assign rem_in = fits ? rem_src - trial : rem_src;
      assign q_in   = fits ? (q_src | (quot_type'(1) << (QBITS - 1 - i))) : q_src;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quot = q_ff[QBITS-1];

endmodule

/* design/boris_particle_push.sv */
// Throughput: one word per cycle while responses are taken; the whole pipeline advances together.
// Most of the pipeline depth lies in the 18-stage divider that forms the rotation scale.
// A stalled response holds every stage in place until it is taken.
// Reset (synchronous) clears all valid bits and loads dt = 6554 and q/m = -1.0.
// Top level of the Boris particle push pipeline.
`include "boris_particle_push_assert.svh"

module boris_particle_push (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  bpp_pkg::csr_idx_type              csr_index,
   input  logic [bpp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   bpp_req_if.sink                           req_chan,
   bpp_rsp_if.source                         rsp_chan
);
   import bpp_pkg::*;

   ts_type   ts_ff, ts_in;
   word_type qm_ff, qm_in;
   word_type hh_ff;
   word_type dt_w;

   logic               en;
   logic               req_take;
   logic [STG_LAST:1]  v_ff;

   vec_type  req_pos, req_vel, req_ef, req_bf;
   vec_type  s1_pos_ff, s1_vel_ff, s1_b_ff, s1_kick_ff, s1_d_ff;
   vec_type  s2_b_ff, s2_kick_ff, s2_sq_ff, s2_um_ff, s2_xh_ff;
   vec_type  s3_b_ff, s3_kick_ff, s3_um_ff, s3_xh_ff;
   word_type s3_den_ff;
   prod_type s3_p_ff;
   vec_type  s4_b_ff, s4_kick_ff, s4_um_ff, s4_xh_ff, s4_uxb_ff;
   vec_type  s5_kick_ff, s5_um_ff, s5_xh_ff, s5_uxb_ff;
   prod_type s5_p_ff;
   dly_type  dly_ff [DLY_N];
   dly_type  dly_in;
   quot_type quot;
   word_type scale;
   vec_type  s22_kick_ff, s22_um_ff, s22_xh_ff, s22_ws_ff;
   vec_type  s23_vn_ff, s23_xh_ff;
   vec_type  s24_vn_ff, s24_xh_ff, s24_d_ff;
   vec_type  out_pos_ff, out_vel_ff;

   // Configuration registers and their next values.
   always_comb begin
      ts_in = ts_ff;
      qm_in = qm_ff;
      if (reset) begin
         ts_in = TS_RESET;
         qm_in = QM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIME_STEP: ts_in = csr_wdata[TS_WIDTH-1:0];
            CSR_QM:        qm_in = csr_wdata[DATA_WIDTH-1:0];
            default:       ;
         endcase
      end
   end

   // The half step factor is registered from the next values, so it changes together with the registers.
   always_ff @(posedge clock) begin
      ts_ff <= ts_in;
      qm_ff <= qm_in;
      hh_ff <= mul_round(qm_in, word_type'(ts_in), FRAC_BITS + 1);
   end

   assign dt_w = word_type'(ts_ff);

   // Global advance: the pipeline moves whenever the output stage is free or taken.
   assign en             = !v_ff[STG_LAST] || rsp_chan.ready;
   assign req_chan.ready = en && !reset;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STG_LAST-1:1], req_take};
      end
   end

   assign req_pos = {req_chan.data.pos_z, req_chan.data.pos_y, req_chan.data.pos_x};
   assign req_vel = {req_chan.data.vel_z, req_chan.data.vel_y, req_chan.data.vel_x};
   assign req_ef  = {req_chan.data.efield_z, req_chan.data.efield_y, req_chan.data.efield_x};
   assign req_bf  = {req_chan.data.bfield_z, req_chan.data.bfield_y, req_chan.data.bfield_x};

   // Stages one to five: scaled fields, half drift, half kick, the divisor and the two cross products.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_pos_ff[i]  <= req_pos[i];
            s1_vel_ff[i]  <= req_vel[i];
            s1_b_ff[i]    <= mul_round(hh_ff, req_bf[i], FRAC_BITS);
            s1_kick_ff[i] <= mul_round(hh_ff, req_ef[i], FRAC_BITS);
            s1_d_ff[i]    <= mul_round(dt_w, req_vel[i], FRAC_BITS + 1);

            s2_b_ff[i]    <= s1_b_ff[i];
            s2_kick_ff[i] <= s1_kick_ff[i];
            s2_sq_ff[i]   <= mul_round(s1_b_ff[i], s1_b_ff[i], FRAC_BITS);
            s2_um_ff[i]   <= add_sat(s1_vel_ff[i], s1_kick_ff[i]);
            s2_xh_ff[i]   <= add_sat(s1_pos_ff[i], s1_d_ff[i]);

            s3_b_ff[i]      <= s2_b_ff[i];
            s3_kick_ff[i]   <= s2_kick_ff[i];
            s3_um_ff[i]     <= s2_um_ff[i];
            s3_xh_ff[i]     <= s2_xh_ff[i];
            s3_p_ff[2*i]    <= mul_round(s2_um_ff[NXT[i]], s2_b_ff[PRV[i]], FRAC_BITS);
            s3_p_ff[2*i+1]  <= mul_round(s2_um_ff[PRV[i]], s2_b_ff[NXT[i]], FRAC_BITS);

            s4_b_ff[i]    <= s3_b_ff[i];
            s4_kick_ff[i] <= s3_kick_ff[i];
            s4_um_ff[i]   <= s3_um_ff[i];
            s4_xh_ff[i]   <= s3_xh_ff[i];
            s4_uxb_ff[i]  <= sub_sat(s3_p_ff[2*i], s3_p_ff[2*i+1]);

            s5_kick_ff[i]  <= s4_kick_ff[i];
            s5_um_ff[i]    <= s4_um_ff[i];
            s5_xh_ff[i]    <= s4_xh_ff[i];
            s5_uxb_ff[i]   <= s4_uxb_ff[i];
            s5_p_ff[2*i]   <= mul_round(s4_uxb_ff[NXT[i]], s4_b_ff[PRV[i]], FRAC_BITS);
            s5_p_ff[2*i+1] <= mul_round(s4_uxb_ff[PRV[i]], s4_b_ff[NXT[i]], FRAC_BITS);
         end
         s3_den_ff <= add_sat(ONE_Q,
                              add_sat(add_sat(s2_sq_ff[0], s2_sq_ff[1]), s2_sq_ff[2]));
      end
   end

   // Rotation sum w = u x b + (u x b) x b enters the delay line.
   always_comb begin
      dly_in.kick = s5_kick_ff;
      dly_in.um   = s5_um_ff;
      dly_in.xh   = s5_xh_ff;
      for (int i = 0; i < 3; i++) begin
         dly_in.w[i] = add_sat(s5_uxb_ff[i], sub_sat(s5_p_ff[2*i], s5_p_ff[2*i+1]));
      end
   end

   // Delay line that waits for the divider.
   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= dly_in;
         for (int k = 1; k < DLY_N; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   bpp_div u_div (
      .clock (clock),
      .en    (en),
      .den   (s3_den_ff),
      .quot  (quot)
   );

   assign scale = word_type'(quot);

   // Final stages: scaled rotation, second kick, second half drift.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s22_kick_ff[i] <= dly_ff[DLY_N-1].kick[i];
            s22_um_ff[i]   <= dly_ff[DLY_N-1].um[i];
            s22_xh_ff[i]   <= dly_ff[DLY_N-1].xh[i];
            s22_ws_ff[i]   <= mul_round(dly_ff[DLY_N-1].w[i], scale, FRAC_BITS);

            s23_vn_ff[i] <= add_sat(add_sat(s22_um_ff[i], s22_ws_ff[i]), s22_kick_ff[i]);
            s23_xh_ff[i] <= s22_xh_ff[i];

            s24_vn_ff[i] <= s23_vn_ff[i];
            s24_xh_ff[i] <= s23_xh_ff[i];
            s24_d_ff[i]  <= mul_round(dt_w, s23_vn_ff[i], FRAC_BITS + 1);

            out_pos_ff[i] <= add_sat(s24_xh_ff[i], s24_d_ff[i]);
            out_vel_ff[i] <= s24_vn_ff[i];
         end
      end
   end

   assign rsp_chan.valid          = v_ff[STG_LAST];
   assign rsp_chan.data.new_pos_x = out_pos_ff[0];
   assign rsp_chan.data.new_pos_y = out_pos_ff[1];
   assign rsp_chan.data.new_pos_z = out_pos_ff[2];
   assign rsp_chan.data.new_vel_x = out_vel_ff[0];
   assign rsp_chan.data.new_vel_y = out_vel_ff[1];
   assign rsp_chan.data.new_vel_z = out_vel_ff[2];

   // Checks on the pipeline control and the divider range.
   `BPP_ASSERT_NEXT(a_take_enters, clock, reset, req_take, v_ff[1], "accepted word lost")
   `BPP_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(v_ff), "stall moved pipeline")
   `BPP_ASSERT_IMPLY(a_scale_range, clock, reset, v_ff[STG_S], quot <= QUOT_MAX, "scale range")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Boris particle push pipeline.
`timescale 1ns / 100ps

module testbench;
   import bpp_pkg::*;

   // Rows of the directed stimulus table.
   typedef struct {
      ts_type       dt;
      word_type     qm;
      req_data_type d;
      bit           typed;
      rsp_data_type r;
   } drow_type;

   typedef longint trio_type [3];

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bpp_req_if req_chan ();
   bpp_rsp_if rsp_chan ();

   boris_particle_push uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Our copy of the two registers.
   ts_type   step_reg;
   word_type qm_reg;

   rsp_data_type pushed_q [$];
   bit           typed_next;
   rsp_data_type typed_val;
   int           errors;
   int           taken;
   int           cycles;
   drow_type     dtab [$];

   // Clamp to the signed word range.
   function automatic longint clamp_w(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Fixed-point product, rounded half up, then clamped.
   function automatic longint fx_mul(input longint a, input longint b, input int sh);
      longint p;
      p = a * b + (64'sd1 <<< (sh - 1));
      return clamp_w(p >>> sh);
   endfunction

   function automatic trio_type fx_cross(input trio_type a, input trio_type b);
      trio_type r;
      for (int i = 0; i < 3; i++)
         r[i] = clamp_w(fx_mul(a[NXT[i]], b[PRV[i]], FRAC_BITS)
                      - fx_mul(a[PRV[i]], b[NXT[i]], FRAC_BITS));
      return r;
   endfunction

   // Advance one particle by a full Boris step with the given registers.
   function automatic rsp_data_type boris_step(input req_data_type d, input ts_type dt_r,
                                               input word_type qm_r);
      trio_type p, v, e, bf, b, kick, um, uxb, uxbxb, w, xh;
      longint dt, hh, bsq, den, s, up, vn, xn;
      rsp_data_type r;
      p  = '{d.pos_x, d.pos_y, d.pos_z};
      v  = '{d.vel_x, d.vel_y, d.vel_z};
      e  = '{d.efield_x, d.efield_y, d.efield_z};
      bf = '{d.bfield_x, d.bfield_y, d.bfield_z};
      dt = longint'(dt_r);
      hh = fx_mul(longint'(qm_r), dt, FRAC_BITS + 1);
      bsq = 0;
      for (int i = 0; i < 3; i++) begin
         b[i] = fx_mul(hh, bf[i], FRAC_BITS);
         bsq = clamp_w(bsq + fx_mul(b[i], b[i], FRAC_BITS));
      end
      den = clamp_w((64'sd1 <<< FRAC_BITS) + bsq);
      if (den < 1) den = 1;
      s = clamp_w(((64'sd2 <<< (2 * FRAC_BITS)) + den / 2) / den);
      for (int i = 0; i < 3; i++) begin
         xh[i] = clamp_w(p[i] + fx_mul(dt, v[i], FRAC_BITS + 1));
         kick[i] = fx_mul(hh, e[i], FRAC_BITS);
         um[i] = clamp_w(v[i] + kick[i]);
      end
      uxb = fx_cross(um, b);
      uxbxb = fx_cross(uxb, b);
      for (int i = 0; i < 3; i++) w[i] = clamp_w(uxb[i] + uxbxb[i]);
      for (int i = 0; i < 3; i++) begin
         up = clamp_w(um[i] + fx_mul(w[i], s, FRAC_BITS));
         vn = clamp_w(up + kick[i]);
         xn = clamp_w(xh[i] + fx_mul(dt, vn, FRAC_BITS + 1));
         r[191 - 32*i -: 32] = word_type'(xn);
         r[95 - 32*i -: 32] = word_type'(vn);
      end
      return r;
   endfunction

   // Mix of full-range, small, zero, unit and extreme values.
   function automatic word_type rand_word();
      case ($urandom_range(0, 6))
         0, 1: return word_type'($urandom);
         2, 3: return word_type'($signed($urandom_range(0, 524288)) - 262144);
         4: return ($urandom_range(0, 1)) ? WORD_MAX : WORD_MIN;
         5: return '0;
         default: return ($urandom_range(0, 1)) ? ONE_Q : -ONE_Q;
      endcase
   endfunction

   function automatic req_data_type rand_req();
      req_data_type d;
      for (int k = 0; k < 12; k++) d[383 - 32*k -: 32] = rand_word();
      return d;
   endfunction

   function automatic void add_row(input ts_type dt, input word_type qm,
                                   input req_data_type d, input bit typed,
                                   input rsp_data_type r);
      drow_type row;
      row.dt = dt; row.qm = qm; row.d = d; row.typed = typed; row.r = r;
      dtab.push_back(row);
   endfunction

   // Clock generation.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Cycle limit.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL boris_particle_push");
         $finish;
      end
   end

   // Each accepted request word queues its expected response word.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         if (typed_next) pushed_q.push_back(typed_val);
         else pushed_q.push_back(boris_step(req_chan.data, step_reg, qm_reg));
      end
   end

   // Each accepted response word is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         taken = taken + 1;
         if (pushed_q.size() == 0) begin
            $display("%0t: response word with nothing expected: %h", $time, rsp_chan.data);
            errors = errors + 1;
         end else begin
            want = pushed_q.pop_front();
            for (int k = 0; k < 6; k++)
               if (want[191 - 32*k -: 32] !== rsp_chan.data[191 - 32*k -: 32]) begin
                  $display("%0t: field %0d expected %h actual %h", $time, k,
                           want[191 - 32*k -: 32], rsp_chan.data[191 - 32*k -: 32]);
                  errors = errors + 1;
               end
         end
      end
   end

   // Response side: random stalls, quiet stretches, and one long hold-off.
   initial begin
      int n;
      bit held;
      rsp_chan.ready = 1'b0;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && taken >= 120) begin
            held = 1;
            n = 150;
         end else if ((taken / 60) % 3 == 1) n = 0;
         else n = $urandom_range(0, 5);
         repeat (n) begin
            rsp_chan.ready = 1'b0;
            @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   task automatic set_regs(input ts_type dt, input word_type qm);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_TIME_STEP;
      csr_wdata = {11'($urandom), dt};
      @(negedge clock);
      csr_index = CSR_QM;
      csr_wdata = qm;
      @(negedge clock);
      csr_wr_en = 1'b0;
      step_reg = dt;
      qm_reg = qm;
   endtask

   // The typed expectation changes together with the data it belongs to.
   task automatic send_word(input req_data_type d, input int gap, input bit typed,
                            input rsp_data_type r);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.data = d;
      typed_next = typed;
      typed_val = r;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Let the pipeline empty before touching the registers again.
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pushed_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Main sequence: directed table, then random phases.
   initial begin
      req_data_type d;
      ts_type dt;
      word_type qm;
      bit quiet;
      errors = 0;
      taken = 0;
      typed_next = 0;
      typed_val = '0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_TIME_STEP;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      step_reg = TS_RESET;
      qm_reg = QM_RESET;

      // Reset defaults first, then zero step, then the largest step and other nonzero steps.
      add_row(TS_RESET, QM_RESET, '0, 1, '0);
      add_row(TS_RESET, QM_RESET, {12{WORD_MAX}}, 0, '0);
      add_row(TS_RESET, QM_RESET, {12{WORD_MIN}}, 0, '0);
      add_row(TS_RESET, QM_RESET, {6{WORD_MAX, WORD_MIN}}, 0, '0);
      add_row(TS_RESET, QM_RESET, {6{WORD_MIN, WORD_MAX}}, 0, '0);
      d = '0;
      d.vel_x = ONE_Q; d.bfield_z = WORD_MAX; d.bfield_x = WORD_MIN;
      add_row(TS_RESET, QM_RESET, d, 0, '0);
      d = '0;
      d.vel_x = ONE_Q; d.vel_y = 2 * ONE_Q; d.efield_z = -3 * ONE_Q; d.bfield_z = ONE_Q;
      add_row(TS_RESET, QM_RESET, d, 0, '0);
      add_row('0, WORD_MAX, {12{WORD_MAX}}, 1, {6{WORD_MAX}});
      add_row('0, WORD_MAX, {12{WORD_MIN}}, 1, {6{WORD_MIN}});
      d = {6{WORD_MIN, WORD_MAX}};
      add_row('0, WORD_MAX, d, 1, d[383:192]);
      add_row(ts_type'('1), WORD_MIN, {12{WORD_MAX}}, 0, '0);
      add_row(ts_type'('1), WORD_MIN, {12{ONE_Q}}, 0, '0);
      add_row(ts_type'('1), WORD_MIN, {12{-ONE_Q}}, 0, '0);
      add_row(ts_type'(1048576), '0, {12{ONE_Q}}, 0, '0);
      add_row(ts_type'(1048576), '0, {6{WORD_MIN, WORD_MAX}}, 0, '0);
      add_row(ts_type'(65536), WORD_MAX, {12{-ONE_Q}}, 0, '0);
      add_row(ts_type'(65536), WORD_MAX, {12{ONE_Q}}, 0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dtab[i]) begin
         if (dtab[i].dt != step_reg || dtab[i].qm != qm_reg) begin
            drain();
            set_regs(dtab[i].dt, dtab[i].qm);
         end
         send_word(dtab[i].d, $urandom_range(0, 5), dtab[i].typed, dtab[i].r);
      end
      drain();
      typed_next = 0;

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 4))
            0: dt = '0;
            1: dt = ts_type'('1);
            2: dt = ts_type'(1048576);
            3: dt = ts_type'($urandom_range(1, 13107));
            default: dt = ts_type'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: qm = WORD_MIN;
            1: qm = WORD_MAX;
            2: qm = '0;
            3: qm = word_type'($signed($urandom_range(0, 262144)) - 131072);
            default: qm = word_type'($urandom);
         endcase
         if (ph == 0) dt = TS_RESET;
         if (ph == 1) qm = QM_RESET;
         set_regs(dt, qm);
         for (int n = 0; n < 75; n++) begin
            quiet = (n / 25) == 1;
            send_word(rand_req(), quiet ? 0 : $urandom_range(0, 5), 1'b0, '0);
         end
         drain();
      end

      if (errors == 0) $display("PASS boris_particle_push");
      else $display("FAIL boris_particle_push");
      $finish;
   end

endmodule
